FILE: src/ira_pkg.sv
// shared constants and radix codes for the integer to ascii converter
package ira_pkg;

  // input value width and derived digit counts
  localparam int VALUE_BITS = 31;
  localparam int BIN_DIGITS = VALUE_BITS;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  // floor(bits * log10(2)) + 1
  localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

  // digit word wide enough for the bcd form and every power-of-two form
  localparam int DIG_W_DEC = 4 * DEC_DIGITS;
  localparam int DIG_W_OCT = 3 * OCT_DIGITS;
  localparam int DIG_W_HEX = 4 * HEX_DIGITS;
  localparam int DIG_W_A   = (DIG_W_DEC > DIG_W_OCT) ? DIG_W_DEC : DIG_W_OCT;
  localparam int DIG_W_B   = (DIG_W_HEX > BIN_DIGITS) ? DIG_W_HEX : BIN_DIGITS;
  localparam int DIG_W     = (DIG_W_A > DIG_W_B) ? DIG_W_A : DIG_W_B;

  // counter holds up to the longest digit string or step count
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  // radix select codes
  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_BIN = 2'd1;
  localparam logic [1:0] OP_OCT = 2'd2;
  localparam logic [1:0] OP_HEX = 2'd3;

  // ascii offsets for digits and upper-case letters
  localparam logic [6:0] ASCII_ZERO = 7'd48;
  localparam logic [6:0] ASCII_BIAS = 7'd55;

endpackage

FILE: src/ira_if.sv
// valid/ready channel interfaces for input items and result items
interface ira_in_if import ira_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface ira_out_if import ira_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: src/integer_to_radix_ascii_core.sv
// top level: converts a non-negative integer to ascii digits, most significant first
// decimal: each of the VALUE_BITS (31) bits passes through the shared shift-add-3 bcd step, then digits
// binary, octal, hex: the emit phase starts the cycle after the item is taken
// emit phase: each digit position in turn, leading zero positions dropped without output
// and digits held back while the output stalls; a new item is taken only in idle, after
// the last digit of the previous one is loaded into the output register; synchronous
// active-low reset clears the sequencer and the output valid
module integer_to_radix_ascii_core import ira_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ira_in_if.sink    in_ch,
  ira_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int BIN_SH = DIG_W - BIN_DIGITS;
  localparam int OCT_SH = DIG_W - DIG_W_OCT;
  localparam int HEX_SH = DIG_W - DIG_W_HEX;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [VALUE_BITS-1:0] shreg_r, shreg_nxt;
  logic [DIG_W-1:0]      dig_r, dig_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  seen_r, seen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [DIG_W-1:0] bcd_step;
  logic [3:0]       cur_digit;
  logic [DIG_W-1:0] dig_shifted;
  logic             is_last;
  logic             skip;
  logic             can_load;
  logic             emit;
  logic             in_take;

  // shared bcd step unit
  ira_dabble u_dabble (
    .bcd     (dig_r),
    .bit_in  (shreg_r[VALUE_BITS-1]),
    .bcd_nxt (bcd_step)
  );

  // handshake signals
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_take           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last       = out_last_r;
  assign can_load          = !out_valid_r || out_ch.ready;

  // current top digit and the word after it is consumed
  always_comb begin
    case (op_r)
      OP_BIN: begin
        cur_digit   = {3'b000, dig_r[DIG_W-1]};
        dig_shifted = {dig_r[DIG_W-2:0], 1'b0};
      end
      OP_OCT: begin
        cur_digit   = {1'b0, dig_r[DIG_W-1 -: 3]};
        dig_shifted = {dig_r[DIG_W-4:0], 3'b000};
      end
      default: begin
        cur_digit   = dig_r[DIG_W-1 -: 4];
        dig_shifted = {dig_r[DIG_W-5:0], 4'b0000};
      end
    endcase
  end

  // leading zeros are dropped, but the final digit always goes out
  assign is_last = (cnt_r == CNT_W'(1));
  assign skip    = (cur_digit == 4'd0) && !seen_r && !is_last;
  assign emit    = (state_r == ST_EMIT) && !skip && can_load;

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    shreg_nxt     = shreg_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt   = in_ch.op;
          seen_nxt = 1'b0;
          case (in_ch.op)
            OP_DEC: begin
              shreg_nxt = in_ch.value;
              dig_nxt   = '0;
              cnt_nxt   = CNT_W'(VALUE_BITS);
              state_nxt = ST_CONV;
            end
            OP_BIN: begin
              dig_nxt   = DIG_W'(in_ch.value) << BIN_SH;
              cnt_nxt   = CNT_W'(BIN_DIGITS);
              state_nxt = ST_EMIT;
            end
            OP_OCT: begin
              dig_nxt   = DIG_W'(in_ch.value) << OCT_SH;
              cnt_nxt   = CNT_W'(OCT_DIGITS);
              state_nxt = ST_EMIT;
            end
            default: begin
              dig_nxt   = DIG_W'(in_ch.value) << HEX_SH;
              cnt_nxt   = CNT_W'(HEX_DIGITS);
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt   = bcd_step;
        shreg_nxt = {shreg_r[VALUE_BITS-2:0], 1'b0};
        if (is_last) begin
          cnt_nxt   = CNT_W'(DEC_DIGITS);
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (skip) begin
          dig_nxt = dig_shifted;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (cur_digit < 4'd10) ? (ASCII_ZERO + 7'(cur_digit))
                                              : (ASCII_BIAS + 7'(cur_digit));
          out_last_nxt  = is_last;
          dig_nxt       = dig_shifted;
          cnt_nxt       = cnt_r - CNT_W'(1);
          seen_nxt      = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    shreg_r    <= shreg_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    seen_r     <= seen_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // counter never runs out while converting or emitting
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV || state_r == ST_EMIT) |-> cnt_r != '0)
    else $error("digit counter empty while busy");

  // every result is a legal digit character
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r >= 7'd48 && out_char_r <= 7'd57) ||
                     (out_char_r >= 7'd65 && out_char_r <= 7'd70)))
    else $error("illegal digit character");

  // the final digit returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("last digit did not end the item");

  // bcd digits stay decimal once conversion is done
  a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && op_r == OP_DEC) |-> dig_r[DIG_W-1 -: 4] <= 4'd9)
    else $error("bcd digit out of range");

endmodule

FILE: src/ira_dabble.sv
// one shift-and-add-3 step of the binary to bcd conversion
module ira_dabble import ira_pkg::*; (
  input  logic [DIG_W-1:0] bcd,
  input  logic             bit_in,
  output logic [DIG_W-1:0] bcd_nxt
);

  logic [DIG_W-1:0] adj;

  // correct every bcd digit of 5 or more before the shift
  always_comb begin
    adj = bcd;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  assign bcd_nxt = {adj[DIG_W-2:0], bit_in};

endmodule

FILE: sim/integer_to_radix_ascii_core_test.sv
// self-checking testbench for the integer to radix ascii converter
module integer_to_radix_ascii_core_test import ira_pkg::*; ();

  // one expected character of a converted number
  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } digit_t;

  // directed row: radix, value and, where obvious, the spelled-out text
  typedef struct {
    logic [1:0]            op;
    logic [VALUE_BITS-1:0] value;
    string                 spelled;
  } stim_row_t;

  localparam int DIR_ROWS     = 25;
  localparam int BATCH_ITEMS  = 112;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;

  // directed table, empty text means the predictor supplies the digits
  stim_row_t stim_rows [DIR_ROWS] = '{
    '{OP_DEC, 31'd0,          "0"},
    '{OP_BIN, 31'd0,          "0"},
    '{OP_OCT, 31'd0,          "0"},
    '{OP_HEX, 31'd0,          "0"},
    '{OP_DEC, 31'h7FFF_FFFF,  "2147483647"},
    '{OP_BIN, 31'h7FFF_FFFF,  {"1111111111", "1111111111", "1111111111", "1"}},
    '{OP_OCT, 31'h7FFF_FFFF,  "17777777777"},
    '{OP_HEX, 31'h7FFF_FFFF,  "7FFFFFFF"},
    '{OP_DEC, 31'd9,          "9"},
    '{OP_DEC, 31'd10,         "10"},
    '{OP_BIN, 31'd1,          "1"},
    '{OP_BIN, 31'd2,          "10"},
    '{OP_OCT, 31'd7,          "7"},
    '{OP_OCT, 31'd8,          "10"},
    '{OP_HEX, 31'd15,         "F"},
    '{OP_HEX, 31'd16,         "10"},
    '{OP_HEX, 31'h00AB_CDEF,  "ABCDEF"},
    '{OP_HEX, 31'h0123_4567,  "1234567"},
    '{OP_DEC, 31'd1000000000, "1000000000"},
    '{OP_BIN, 31'h4000_0000,  ""},
    '{OP_DEC, 31'd1234567890, ""},
    '{OP_OCT, 31'o12345670,   ""},
    '{OP_HEX, 31'h2AAA_AAAA,  ""},
    '{OP_BIN, 31'h5555_5555,  ""},
    '{OP_DEC, 31'd4095,       ""}
  };

  logic clk;
  logic rst_n;

  ira_in_if  in_ch ();
  ira_out_if out_ch ();

  integer_to_radix_ascii_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digit_t digit_exp_q [$];
  string  spelling_q [$];

  int src_idle_pct;
  int sink_idle_pct;
  int fail_count = 0;
  int items_sent;
  int digits_checked = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // digits of value in the selected radix, most significant first
  function automatic void predict_digits(input logic [1:0] op,
                                         input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    logic [4:0]            radix;
    logic [4:0]            d;
    logic [6:0]            digits [VALUE_BITS];
    int                    count;
    digit_t                e;
    rest  = value;
    count = 0;
    case (op)
      OP_BIN:  radix = 5'd2;
      OP_OCT:  radix = 5'd8;
      OP_HEX:  radix = 5'd16;
      default: radix = 5'd10;
    endcase
    // least significant digit first, zero still gives one digit
    do begin
      d = 5'(rest % radix);
      digits[count] = (d < 5'd10) ? ASCII_ZERO + 7'(d) : ASCII_BIAS + 7'(d);
      count++;
      rest = rest / radix;
    end while (rest != '0);
    for (int k = 0; k < count; k++) begin
      e.digit_char = digits[count - 1 - k];
      e.last       = (k == count - 1);
      digit_exp_q.push_back(e);
    end
  endfunction

  // present one number and hold it until taken
  task automatic drive_number(input logic [1:0] op, input logic [VALUE_BITS-1:0] value,
                              input string spelled);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    spelling_q.push_back(spelled);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // random numbers of random bit length, a few zeros among them
  task automatic run_random_batch(input int n);
    int                    width;
    logic [31:0]           raw;
    logic [VALUE_BITS-1:0] value;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        value = '0;
      end else begin
        width = $urandom_range(1, VALUE_BITS);
        raw   = $urandom;
        value = raw[VALUE_BITS-1:0] & VALUE_BITS'((32'd1 << width) - 32'd1);
      end
      drive_number(2'($urandom_range(0, 3)), value, "");
    end
  endtask

  // lower valid and hold off until every expected digit has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digit_exp_q.size() != 0 || spelling_q.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // scoreboard: record accepted numbers, check accepted digits
  always @(posedge clk) begin : scoreboard
    string  spelled;
    digit_t e;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        spelled = spelling_q.pop_front();
        if (spelled.len() != 0) begin
          for (int i = 0; i < spelled.len(); i++) begin
            e.digit_char = 7'(spelled[i]);
            e.last       = (i == spelled.len() - 1);
            digit_exp_q.push_back(e);
          end
        end else begin
          predict_digits(in_ch.op, in_ch.value);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digit_exp_q.size() == 0) begin
          $error("unexpected digit item: digit_char %0d last %0b",
                 out_ch.digit_char, out_ch.last);
          fail_count++;
        end else begin
          e = digit_exp_q.pop_front();
          digits_checked++;
          if (out_ch.digit_char !== e.digit_char) begin
            $error("digit_char: expected %0d, got %0d", e.digit_char, out_ch.digit_char);
            fail_count++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_ch.last);
            fail_count++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_DEC;
    in_ch.value    = '0;
    src_idle_pct   = 6;
    sink_idle_pct  = 72;
    items_sent     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, then random with a slow receiver
    for (int r = 0; r < DIR_ROWS; r++) begin
      drive_number(stim_rows[r].op, stim_rows[r].value, stim_rows[r].spelled);
    end
    run_random_batch(BATCH_ITEMS);
    drain_results();

    // slow sender, quick receiver
    src_idle_pct  = 72;
    sink_idle_pct = 6;
    run_random_batch(BATCH_ITEMS);

    // back to back
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random_batch(BATCH_ITEMS);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers across all four radixes, %0d digit items checked",
             items_sent, digits_checked);
    $display("idle mixes: slow receiver, slow sender, none; one full drain mid-run");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
